// ===== rtl/adlf_pkg.sv =====
// ----------------------------------------------------------------------------
// adlf_pkg
// Shared constants, types and helpers of the adjacent duplicate line filter.
// ----------------------------------------------------------------------------
package adlf_pkg;

    // line store geometry
    localparam int MAX_LINE   = 256;
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int LEN_W      = $clog2(MAX_LINE + 1);
    localparam int ADDR_W     = POS_W + 1;
    localparam int STORE_SIZE = 2 * MAX_LINE;

    // run counter, saturating
    localparam int COUNT_BITS = 16;

    // port widths fixed by the interface
    localparam int MODE_W      = 2;
    localparam int LIMIT_W     = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int START_W     = 32;
    localparam int OUT_COUNT_W = 16;
    localparam int OUT_BYTES_W = 9;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIECE_LIMIT = 1'd1;

    // reset values of the registers
    localparam logic [MODE_W-1:0]  FILTER_MODE_RESET = 2'd0;
    localparam logic [LIMIT_W-1:0] PIECE_LIMIT_RESET = 9'd255;

    // filter mode bits
    localparam int MODE_UNIQUE_BIT   = 0;
    localparam int MODE_REPEATED_BIT = 1;

    // newline byte ends a piece
    localparam logic [7:0] NL_BYTE = 8'd10;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // item after the store read has been issued
    typedef struct packed {
        logic             eos;
        logic             close;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
    } piece_item_t;

    // one reported run
    typedef struct packed {
        logic [START_W-1:0]     start;
        logic [OUT_COUNT_W-1:0] count;
        logic [OUT_BYTES_W-1:0] bytes;
        logic                   last;
    } run_result_t;

    // mode filter, the unique bit takes priority over the repeated bit
    function automatic logic passes_filter(logic [MODE_W-1:0] mode,
                                           logic [COUNT_BITS-1:0] cnt);
        logic single;
        single = (cnt == COUNT_BITS'(1));
        if (mode[MODE_UNIQUE_BIT])
            return single;
        else if (mode[MODE_REPEATED_BIT])
            return !single;
        else
            return 1'b1;
    endfunction

endpackage

// ===== rtl/adlf_line_store.sv =====
// ----------------------------------------------------------------------------
// adlf_line_store
// Ping-pong line store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module adlf_line_store (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [adlf_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [adlf_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import adlf_pkg::*;

    logic [7:0] mem [STORE_SIZE];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/adlf_run_tracker.sv =====
// ----------------------------------------------------------------------------
// adlf_run_tracker
// Compares each byte against the previous piece, counts runs of equal
// pieces and produces up to two run reports per item.
// ----------------------------------------------------------------------------
module adlf_run_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  adlf_pkg::piece_item_t       item,
    input  logic [7:0]                  rd_data,
    input  logic [adlf_pkg::MODE_W-1:0] filter_mode,
    output logic [1:0]                  push_cnt,
    output adlf_pkg::run_result_t       push_a,
    output adlf_pkg::run_result_t       push_b
);
    import adlf_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    logic                   have_prev_reg, have_prev_next;
    logic                   mismatch_reg, mismatch_next;
    logic [LEN_W-1:0]       prev_len_reg, prev_len_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [START_W-1:0]     first_reg, first_next;
    logic [START_W-1:0]     index_reg, index_next;

    logic                   mm_now;
    logic                   mism_eff;
    logic                   same;
    logic                   emit_close;
    logic                   emit_flush;
    logic                   a_have;
    logic [LEN_W-1:0]       a_plen;
    logic [COUNT_BITS-1:0]  a_count;
    logic [START_W-1:0]     a_first;
    logic [START_W-1:0]     a_index;
    logic                   a_mm;
    run_result_t            res_close;
    run_result_t            res_flush;

    // byte compare and piece close
    always_comb
    begin
        mm_now   = !have_prev_reg || (LEN_W'(item.pos) >= prev_len_reg) ||
                   (rd_data != item.data);
        mism_eff = item.eos ? mismatch_reg : (mismatch_reg | mm_now);
        same     = have_prev_reg && !mism_eff && (item.len == prev_len_reg);

        a_have     = have_prev_reg;
        a_plen     = prev_len_reg;
        a_count    = count_reg;
        a_first    = first_reg;
        a_index    = index_reg;
        a_mm       = mism_eff;
        emit_close = 1'b0;

        if (item.close)
        begin
            if (same)
            begin
                if (count_reg != COUNT_TOP)
                begin
                    a_count = count_reg + COUNT_BITS'(1);
                end
            end
            else
            begin
                emit_close = have_prev_reg && passes_filter(filter_mode, count_reg);
                a_first    = index_reg;
                a_count    = COUNT_BITS'(1);
            end
            a_plen  = item.len;
            a_have  = 1'b1;
            a_index = index_reg + START_W'(1);
            a_mm    = 1'b0;
        end

        emit_flush = item.eos && a_have && passes_filter(filter_mode, a_count);
    end

    // report records
    always_comb
    begin
        res_close.start = first_reg;
        res_close.count = OUT_COUNT_W'(count_reg);
        res_close.bytes = OUT_BYTES_W'(prev_len_reg);
        res_close.last  = !emit_flush;

        res_flush.start = a_first;
        res_flush.count = OUT_COUNT_W'(a_count);
        res_flush.bytes = OUT_BYTES_W'(a_plen);
        res_flush.last  = 1'b1;

        push_a   = emit_close ? res_close : res_flush;
        push_b   = res_flush;
        push_cnt = fire ? (2'(emit_close) + 2'(emit_flush)) : 2'd0;
    end

    // next state, end of stream returns to reset values
    always_comb
    begin
        if (item.eos)
        begin
            have_prev_next = 1'b0;
            mismatch_next  = 1'b0;
            prev_len_next  = '0;
            count_next     = '0;
            first_next     = '0;
            index_next     = '0;
        end
        else
        begin
            have_prev_next = a_have;
            mismatch_next  = a_mm;
            prev_len_next  = a_plen;
            count_next     = a_count;
            first_next     = a_first;
            index_next     = a_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
            prev_len_reg  <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            index_reg     <= '0;
        end
        else if (fire)
        begin
            have_prev_reg <= have_prev_next;
            mismatch_reg  <= mismatch_next;
            prev_len_reg  <= prev_len_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            index_reg     <= index_next;
        end
    end

endmodule

// ===== rtl/adlf_result_fifo.sv =====
// ----------------------------------------------------------------------------
// adlf_result_fifo
// Small result queue: takes up to two reports per cycle, hands out one while pop is high.
// ----------------------------------------------------------------------------
module adlf_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_cnt,
    input  adlf_pkg::run_result_t push_a,
    input  adlf_pkg::run_result_t push_b,
    output logic                  room,
    output logic                  head_valid,
    output adlf_pkg::run_result_t head,
    input  logic                  pop
);
    import adlf_pkg::*;

    run_result_t           entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    // pointer and fill bookkeeping
    always_comb
    begin
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entries[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            entries[wr_ptr_reg + FIFO_PTR_W'(1)] <= push_b;
        end
    end

    assign room       = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];

    // queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

// ===== rtl/adjacent_duplicate_line_filter.sv =====
// ----------------------------------------------------------------------------
// adjacent_duplicate_line_filter
// Adjacent duplicate line filter over a text byte stream, reporting runs
// of equal line pieces.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    data_byte, end_of_stream
//  out      out_valid / out_stall  run_start, run_count, run_bytes, last_result
//  cfg      cfg_we                 cfg_index, cfg_data
//
//  One item per cycle while in_stall is low: the store write and the compare
//  read of a byte are issued in the cycle it is taken, the compare and run
//  update follow when the waiting item fires, on the registered read data.
//  A report passes the item register and the result queue to out_valid; the
//  queue hands out one report per cycle while out_stall is low, an end of stream may queue two.
//  Reset clears all control state; the line store needs no clearing pass.
//  in_stall rises only while the result queue lacks room for two reports.
// ----------------------------------------------------------------------------
module adjacent_duplicate_line_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              end_of_stream,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [adlf_pkg::START_W-1:0]      run_start,
    output logic [adlf_pkg::OUT_COUNT_W-1:0]  run_count,
    output logic [adlf_pkg::OUT_BYTES_W-1:0]  run_bytes,
    output logic                              last_result,
    // configuration
    input  logic                              cfg_we,
    input  logic [adlf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [adlf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adlf_pkg::*;

    logic [MODE_W-1:0]  filter_mode_reg;
    logic [LIMIT_W-1:0] piece_limit_reg;

    logic [POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic               half_reg, half_next;
    logic               s1_valid_reg;
    piece_item_t        s1_item_reg, s1_item_next;

    logic               accept;
    logic               s1_fire;
    logic [LEN_W-1:0]   lim_eff;
    logic [LEN_W-1:0]   pos_plus;
    logic [7:0]         rd_data;
    logic               fifo_room;
    logic [1:0]         push_cnt;
    run_result_t        push_a;
    run_result_t        push_b;
    run_result_t        head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= FILTER_MODE_RESET;
            piece_limit_reg <= PIECE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_MODE: filter_mode_reg <= cfg_data[MODE_W-1:0];
                REG_PIECE_LIMIT: piece_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshake
    assign s1_fire  = s1_valid_reg && fifo_room;
    assign in_stall = s1_valid_reg && !fifo_room;
    assign accept   = in_valid && !in_stall;

    // piece limit clamped to 1..MAX_LINE
    always_comb
    begin
        if (piece_limit_reg == '0)
            lim_eff = LEN_W'(1);
        else if (32'(piece_limit_reg) > 32'(MAX_LINE))
            lim_eff = LEN_W'(MAX_LINE);
        else
            lim_eff = LEN_W'(piece_limit_reg);
    end

    // byte position and half tracking, piece end detection
    always_comb
    begin
        pos_plus           = LEN_W'(byte_pos_reg) + LEN_W'(1);
        s1_item_next.eos   = end_of_stream;
        s1_item_next.data  = data_byte;
        s1_item_next.pos   = byte_pos_reg;
        byte_pos_next      = byte_pos_reg;
        half_next          = half_reg;
        if (end_of_stream)
        begin
            s1_item_next.close = (byte_pos_reg != '0);
            s1_item_next.len   = LEN_W'(byte_pos_reg);
            byte_pos_next      = '0;
            half_next          = 1'b0;
        end
        else
        begin
            s1_item_next.close = (data_byte == NL_BYTE) || (pos_plus >= lim_eff);
            s1_item_next.len   = pos_plus;
            if (s1_item_next.close)
            begin
                byte_pos_next = '0;
                half_next     = !half_reg;
            end
            else
            begin
                byte_pos_next = POS_W'(pos_plus);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
            half_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                byte_pos_reg <= byte_pos_next;
                half_reg     <= half_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    // item payload waiting for store read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    // store: write this half, read the other half at the same position
    adlf_line_store u_store (
        .clk     (clk),
        .wr_en   (accept && !end_of_stream),
        .wr_addr ({half_reg, byte_pos_reg}),
        .wr_data (data_byte),
        .rd_en   (accept),
        .rd_addr ({!half_reg, byte_pos_reg}),
        .rd_data (rd_data)
    );

    adlf_run_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .item        (s1_item_reg),
        .rd_data     (rd_data),
        .filter_mode (filter_mode_reg),
        .push_cnt    (push_cnt),
        .push_a      (push_a),
        .push_b      (push_b)
    );

    adlf_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_a     (push_a),
        .push_b     (push_b),
        .room       (fifo_room),
        .head_valid (out_valid),
        .head       (head),
        .pop        (!out_stall)
    );

    assign run_start   = head.start;
    assign run_count   = head.count;
    assign run_bytes   = head.bytes;
    assign last_result = head.last;

    // an open piece never reaches the store half size
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(byte_pos_reg) < 32'(MAX_LINE))
        else $error("byte position past line store half");

    // end of stream restarts position and half
    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_stream |=> byte_pos_reg == '0 && !half_reg)
        else $error("end of stream did not restart piece tracking");

    // two reports only come from an end of stream
    a_two_only_eos: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> s1_item_reg.eos)
        else $error("double report without end of stream");

    // reports are only queued when the waiting item moves on
    a_push_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> s1_fire)
        else $error("report queued without item");

endmodule
